@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL. Clock and reset names are fixed
// to clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, held off while in reset.
`define MRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/mrq_pkg.sv @@
// ----------------------------------------------------------------------------
// mrq_pkg
// Command and status codes, field widths and the stored entry type of the
// message ring queue.
// ----------------------------------------------------------------------------
package mrq_pkg;

  localparam int CMD_W    = 2;
  localparam int MSG_ID_W = 16;
  localparam int SENDER_W = 8;
  localparam int PAYLD_W  = 64;
  localparam int OFS_W    = 4;
  localparam int STAT_W   = 3;
  localparam int SEQ_W    = 32;
  localparam int COUNT_W  = 4;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROBE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd3;

  // Result status
  localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OVWR  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_SAME  = 3'd4;

  // One stored message
  typedef struct packed {
    logic [MSG_ID_W-1:0] msg_id;
    logic [SENDER_W-1:0] sender;
    logic [PAYLD_W-1:0]  payload;
    logic [SEQ_W-1:0]    seq_num;
  } entry_t;

endpackage

@@ sv/mrq_if.sv @@
// ----------------------------------------------------------------------------
// mrq_if
// Valid/ready channels of the message ring queue: the command channel and
// the result channel.
// ----------------------------------------------------------------------------
interface mrq_in_if;
  import mrq_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [MSG_ID_W-1:0] msg_id;
  logic [SENDER_W-1:0] sender;
  logic [PAYLD_W-1:0]  payload;
  logic [OFS_W-1:0]    first_offset;
  logic [OFS_W-1:0]    second_offset;

  modport source (
    output valid, command, msg_id, sender, payload, first_offset, second_offset,
    input  ready
  );
  modport sink (
    input  valid, command, msg_id, sender, payload, first_offset, second_offset,
    output ready
  );
endinterface

interface mrq_out_if;
  import mrq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [MSG_ID_W-1:0] out_msg_id;
  logic [SENDER_W-1:0] out_sender;
  logic [PAYLD_W-1:0]  out_payload;
  logic [SEQ_W-1:0]    out_sequence;
  logic [COUNT_W-1:0]  entry_count;
  logic                is_full;
  logic                is_empty;

  modport source (
    output valid, status, out_msg_id, out_sender, out_payload, out_sequence,
           entry_count, is_full, is_empty,
    input  ready
  );
  modport sink (
    input  valid, status, out_msg_id, out_sender, out_payload, out_sequence,
           entry_count, is_full, is_empty,
    output ready
  );
endinterface

@@ sv/message_ring_queue_top.sv @@
// ----------------------------------------------------------------------------
// message_ring_queue_top
// Ring queue of DEPTH slots holding up to DEPTH-1 stamped messages, with
// push (optionally overwriting when full), pop, probe and move commands.
// ----------------------------------------------------------------------------
// Each command transfer yields exactly one result transfer, held in an output
// register. A new command is taken only while the sequencer is idle and that
// register is empty or transfers its result in the same cycle, so a waiting
// result stalls the command channel. Entries live in one synchronous memory
// (one write port, one read port, registered read). A push, and any command
// that fails its checks, loads its result in the cycle it is accepted. Pop
// and probe load the registered memory read data from the S_READ state. A
// move fetches the moved entry, makes one memory write per shifted entry
// through the single write port, and a last write of the moved entry. No
// clearing pass follows reset; only held entries are ever read. DEPTH must
// be a power of two.
module message_ring_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  mrq_in_if.sink    in_i,
  mrq_out_if.source out_o
);
  import mrq_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = (AW > OFS_W) ? AW : OFS_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MVTMP = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;

  // Slot of an offset counted from the oldest entry
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                            input logic [OFS_W-1:0] ofs);
    logic [CW-1:0] sum;
    sum = CW'(base) + CW'(ofs);
    return sum[AW-1:0];
  endfunction

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic             ovw_q;
  logic [OFS_W-1:0] first_q, first_d, second_q, second_d, k_q, k_d, nk;
  logic             down_q, down_d;
  entry_t           tmp_q, tmp_d;

  entry_t           mem_q [DEPTH];
  entry_t           rd_data_q;
  logic [AW-1:0]    rd_addr, mem_wa;
  logic             mem_we;
  entry_t           mem_wd;

  logic             in_rdy, in_acc;
  logic [AW-1:0]    held, held_new;
  logic [CW-1:0]    held_cw, held_new_cw;

  logic             load;
  logic [STAT_W-1:0] ld_status;
  entry_t           ld_entry;

  logic             out_vld_q;
  logic [STAT_W-1:0] o_status_q;
  entry_t           o_entry_q;
  logic [COUNT_W-1:0] o_count_q;
  logic             o_full_q, o_empty_q;

  assign in_rdy   = (state_q == S_IDLE) && (!out_vld_q || out_o.ready);
  assign in_acc   = in_i.valid && in_rdy;
  assign in_i.ready = in_rdy;

  assign held    = wp_q - rp_q;
  assign held_cw = CW'(held);

  // Sequencer: checks, pointer updates and memory accesses
  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    seq_d     = seq_q;
    first_d   = first_q;
    second_d  = second_q;
    down_d    = down_q;
    k_d       = k_q;
    tmp_d     = tmp_q;
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    load      = 1'b0;
    ld_status = STAT_OK;
    ld_entry  = '0;
    nk        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.command)
            CMD_PUSH: begin
              load = 1'b1;
              if ((&held) && !ovw_q) begin
                ld_status = STAT_FULL;
              end else begin
                if (&held) begin
                  rp_d      = rp_q + AW'(1);
                  ld_status = STAT_OVWR;
                end
                seq_d  = seq_q + 32'd1;
                mem_we = 1'b1;
                mem_wa = wp_q;
                mem_wd = '{msg_id: in_i.msg_id, sender: in_i.sender,
                           payload: in_i.payload, seq_num: seq_q + 32'd1};
                wp_d   = wp_q + AW'(1);
              end
            end
            CMD_POP: begin
              if (held == '0) begin
                load      = 1'b1;
                ld_status = STAT_RANGE;
              end else begin
                rd_addr = rp_q;
                rp_d    = rp_q + AW'(1);
                state_d = S_READ;
              end
            end
            CMD_PROBE: begin
              if (CW'(in_i.first_offset) >= held_cw) begin
                load      = 1'b1;
                ld_status = STAT_RANGE;
              end else begin
                rd_addr = slot_at(rp_q, in_i.first_offset);
                state_d = S_READ;
              end
            end
            CMD_MOVE: begin
              if (in_i.first_offset == in_i.second_offset) begin
                load      = 1'b1;
                ld_status = STAT_SAME;
              end else if ((CW'(in_i.first_offset) >= held_cw) ||
                           (CW'(in_i.second_offset) >= held_cw)) begin
                load      = 1'b1;
                ld_status = STAT_RANGE;
              end else begin
                rd_addr  = slot_at(rp_q, in_i.second_offset);
                first_d  = in_i.first_offset;
                second_d = in_i.second_offset;
                down_d   = in_i.second_offset > in_i.first_offset;
                state_d  = S_MVTMP;
              end
            end
          endcase
        end
      end
      S_READ: begin
        load     = 1'b1;
        ld_entry = rd_data_q;
        state_d  = S_IDLE;
      end
      S_MVTMP: begin
        // keep the moved entry, fetch its neighbor toward the target
        tmp_d   = rd_data_q;
        k_d     = second_q;
        rd_addr = slot_at(rp_q, down_q ? second_q - 4'd1 : second_q + 4'd1);
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        // slot k takes its neighbor, then step toward the target
        mem_we  = 1'b1;
        mem_wa  = slot_at(rp_q, k_q);
        mem_wd  = rd_data_q;
        nk      = down_q ? k_q - 4'd1 : k_q + 4'd1;
        k_d     = nk;
        if (nk == first_q) begin
          state_d = S_LAST;
        end else begin
          rd_addr = slot_at(rp_q, down_q ? nk - 4'd1 : nk + 4'd1);
        end
      end
      S_LAST: begin
        mem_we  = 1'b1;
        mem_wa  = slot_at(rp_q, first_q);
        mem_wd  = tmp_q;
        load    = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign held_new    = wp_d - rp_d;
  assign held_new_cw = CW'(held_new);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      seq_q     <= '0;
      ovw_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      seq_q   <= seq_d;
      if (cfg_we_i) begin
        ovw_q <= cfg_wdata_i;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Move bookkeeping and result payload
  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
    down_q   <= down_d;
    k_q      <= k_d;
    tmp_q    <= tmp_d;
    if (load) begin
      o_status_q <= ld_status;
      o_entry_q  <= ld_entry;
      o_count_q  <= (held_new_cw > CW'(15)) ? 4'd15 : held_new_cw[COUNT_W-1:0];
      o_full_q   <= &held_new;
      o_empty_q  <= (held_new == '0);
    end
  end

  // Entry memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.status       = o_status_q;
  assign out_o.out_msg_id   = o_entry_q.msg_id;
  assign out_o.out_sender   = o_entry_q.sender;
  assign out_o.out_payload  = o_entry_q.payload;
  assign out_o.out_sequence = o_entry_q.seq_num;
  assign out_o.entry_count  = o_count_q;
  assign out_o.is_full      = o_full_q;
  assign out_o.is_empty     = o_empty_q;

  // Checks
  `MRQ_ASSERT(a_no_result_overrun, load |-> (!out_vld_q || out_o.ready), "result register overrun")
  `MRQ_ASSERT(a_reject_holds, (in_acc && in_i.command == CMD_PUSH && (&held) && !ovw_q) |=> ($stable(wp_q) && $stable(rp_q) && $stable(seq_q)), "rejected push changed state")
  `MRQ_ASSERT(a_move_keeps_ptrs, (state_q == S_SHIFT || state_q == S_MVTMP) |=> ($stable(wp_q) && $stable(rp_q)), "pointers changed during move")
  `MRQ_ASSERT_ALWAYS(a_shift_before_target, (state_q == S_SHIFT) |-> (k_q != first_q), "shift reached move target")
endmodule
